FILE: hw/rtl/pdre_pkg.sv
// pdre_pkg: shared types, constants and tables of the distance rbf expander
package pdre_pkg;

    localparam int unsigned BIN_W      = 6;
    localparam int unsigned BASIS_W    = 16;
    localparam int unsigned DIST_W     = 21;
    localparam int unsigned RAD_W      = 44;
    localparam int unsigned ROOT_W     = 22;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [DIST_W-1:0] DIST_MAX = 21'h1FFFFF;
    // center spacing in units of 1/5120 sigma
    localparam logic [26:0] SPAN_Q = 27'd5120;
    // smallest offset whose square reaches x >= 12
    localparam logic [26:0] E_CUT = 27'd25083;
    // floor(2^35 / 25)
    localparam logic [30:0] RECIP25 = 31'd1374389534;

    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        logic              vld;
        logic [BIN_W-1:0]  bin;
        dist_t             pair_dist;
        logic              last;
        logic              zero;
    } tag_t;

    // floor(b * 128 / 25) for a remainder below 25
    function automatic logic [6:0] frac128(input logic [4:0] b);
        logic [6:0] r;
        case (b)
            5'd0:    r = 7'd0;
            5'd1:    r = 7'd5;
            5'd2:    r = 7'd10;
            5'd3:    r = 7'd15;
            5'd4:    r = 7'd20;
            5'd5:    r = 7'd25;
            5'd6:    r = 7'd30;
            5'd7:    r = 7'd35;
            5'd8:    r = 7'd40;
            5'd9:    r = 7'd46;
            5'd10:   r = 7'd51;
            5'd11:   r = 7'd56;
            5'd12:   r = 7'd61;
            5'd13:   r = 7'd66;
            5'd14:   r = 7'd71;
            5'd15:   r = 7'd76;
            5'd16:   r = 7'd81;
            5'd17:   r = 7'd87;
            5'd18:   r = 7'd92;
            5'd19:   r = 7'd97;
            5'd20:   r = 7'd102;
            5'd21:   r = 7'd107;
            5'd22:   r = 7'd112;
            5'd23:   r = 7'd117;
            5'd24:   r = 7'd122;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/pdre_front.sv
// pdre_front: takes a coordinate pair and works out its distance with a bitwise root
module pdre_front #(
    parameter int COORD_BITS = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [6*COORD_BITS-1:0]             coords,
    output logic                                push_valid,
    input  logic                                push_ready,
    output pdre_pkg::dist_t                     push_dist
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;
    localparam logic [4:0] LAST_STEP = 5'(pdre_pkg::ROOT_W - 1);

    logic [2:0]  state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic        sat_reg, sat_next;
    logic [20:0] d_reg [3];
    logic [20:0] d_next [3];
    logic [41:0] sq_reg [3];
    logic [pdre_pkg::RAD_W-1:0]  rad_reg;
    logic [pdre_pkg::ROOT_W+1:0] rem_reg;
    logic [pdre_pkg::ROOT_W-1:0] root_reg;
    logic [pdre_pkg::ROOT_W+3:0] cat;
    logic [pdre_pkg::ROOT_W+3:0] trial;
    logic        ge;

    always_comb begin
        logic [COORD_BITS:0] df;
        logic [COORD_BITS:0] mg;
        logic [63:0]         ex;
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            df = {coords[i*COORD_BITS+COORD_BITS-1], coords[i*COORD_BITS +: COORD_BITS]}
               - {coords[(i+3)*COORD_BITS+COORD_BITS-1], coords[(i+3)*COORD_BITS +: COORD_BITS]};
            mg = df[COORD_BITS] ? (~df + 1'b1) : df;
            ex = 64'(mg);
            sat_next = sat_next | (|ex[63:21]);
            d_next[i] = ex[20:0];
        end
    end

    // one root bit per cycle
    assign cat   = {rem_reg, rad_reg[pdre_pkg::RAD_W-1 -: 2]};
    assign trial = (pdre_pkg::ROOT_W+4)'({root_reg, 2'b01});
    assign ge    = cat >= trial;

    assign s_tready   = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_dist  = (sat_reg || root_reg[pdre_pkg::ROOT_W-1]) ? pdre_pkg::DIST_MAX
                                                                   : root_reg[20:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_SQ;
            ST_SQ:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_ROOT;
            ST_ROOT: if (cnt_reg == LAST_STEP) state_next = ST_PUSH;
            ST_PUSH: if (push_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                sat_reg <= sat_next;
                for (int i = 0; i < 3; i++) d_reg[i] <= d_next[i];
            end
            ST_SQ: begin
                for (int i = 0; i < 3; i++) sq_reg[i] <= 42'(d_reg[i]) * 42'(d_reg[i]);
            end
            ST_SUM: begin
                rad_reg  <= 44'(sq_reg[0]) + 44'(sq_reg[1]) + 44'(sq_reg[2]);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_ROOT: begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= ge ? (pdre_pkg::ROOT_W+2)'(cat - trial)
                               : (pdre_pkg::ROOT_W+2)'(cat);
                root_reg <= {root_reg[pdre_pkg::ROOT_W-2:0], ge};
                cnt_reg  <= cnt_reg + 5'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/pdre_fifo.sv
// pdre_fifo: two-entry queue of distances between front and back
module pdre_fifo #(
    parameter int WIDTH = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_pop,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             wr_en, rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

endmodule

FILE: hw/rtl/pdre_back.sv
// pdre_back: bin sequencer and pipelined gaussian evaluation with output register
module pdre_back #(
    parameter int NUM_BINS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  pdre_pkg::dist_t                   q_dist,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pdre_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);

    localparam int NT  = 11;
    localparam int NSQ = 4;

    logic adv;
    logic [pdre_pkg::BIN_W-1:0] k_reg;
    logic       k_last;
    logic [26:0] scaled, center, e_full;
    pdre_pkg::tag_t t_in;

    pdre_pkg::tag_t t0_reg, t1_reg, t2_reg, t3_reg, to_reg;
    logic [14:0] e0_reg;
    logic [29:0] e2_1_reg, e2_2_reg;
    logic [60:0] p2_reg;
    logic [31:0] y3_reg;
    logic [32:0] s3_reg;
    logic [pdre_pkg::BASIS_W-1:0] basis_reg;

    logic [25:0] a0, a_q;
    logic [29:0] rr;
    logic [4:0]  b_q;

    pdre_pkg::tag_t tm_reg [NT];
    pdre_pkg::tag_t tr_reg [NT];
    pdre_pkg::tag_t tc_reg [NT];
    logic [63:0] prod_reg [NT];
    logic [31:0] ym_reg [NT];
    logic [31:0] yr_reg [NT];
    logic [31:0] yc_reg [NT-1];
    logic [32:0] sm_reg [NT];
    logic [32:0] sr_reg [NT];
    logic [32:0] sc_reg [NT];
    logic [31:0] v_reg [NT];
    logic [65:0] pm_reg [NT];
    logic [31:0] term_reg [NT-1];

    pdre_pkg::tag_t tq_reg [NSQ];
    logic [30:0] sq_reg [NSQ];

    logic [31:0] rnd_sum;
    logic [16:0] rnd;

    // whole pipeline moves together; the output register frees on a take
    assign adv = !to_reg.vld || m_tready;

    assign k_last = (k_reg == pdre_pkg::BIN_W'(NUM_BINS - 1));
    assign q_pop  = adv && q_valid && k_last;

    assign scaled = 27'(q_dist) * 27'(NUM_BINS - 1);
    assign center = 27'(k_reg) * pdre_pkg::SPAN_Q;
    assign e_full = (scaled >= center) ? (scaled - center) : (center - scaled);

    always_comb begin
        t_in           = '0;
        t_in.vld       = q_valid;
        t_in.bin       = k_reg;
        t_in.pair_dist = q_dist;
        t_in.last      = k_last;
        t_in.zero      = (e_full >= pdre_pkg::E_CUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else if (adv && q_valid) begin
            k_reg <= k_last ? '0 : k_reg + 1'b1;
        end
    end

    // quotient and remainder of e^2 by 25
    assign a0  = p2_reg[60:35];
    assign rr  = e2_2_reg - 30'(a0 * 26'd25);
    assign a_q = (rr >= 30'd25) ? a0 + 26'd1 : a0;
    assign b_q = (rr >= 30'd25) ? 5'(rr - 30'd25) : 5'(rr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_reg <= '0;
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end else if (adv) begin
            t0_reg <= t_in;
            t1_reg <= t0_reg;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e0_reg   <= e_full[14:0];
            e2_1_reg <= 30'(e0_reg) * 30'(e0_reg);
            e2_2_reg <= e2_1_reg;
            p2_reg   <= 61'(e2_1_reg) * 61'(pdre_pkg::RECIP25);
            // y = x/16 in q32, first series term is y itself
            y3_reg   <= 32'({a_q, 7'd0}) + 32'(pdre_pkg::frac128(b_q));
            s3_reg   <= 33'h1_0000_0000 - 33'({a_q, 7'd0}) - 33'(pdre_pkg::frac128(b_q));
        end
    end

    // series terms two through twelve: multiply, reciprocal, correct
    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam int N = j + 2;
        localparam logic [33:0] RCP = 34'((64'd1 << 34) / N);
        pdre_pkg::tag_t t_i;
        logic [31:0] y_i, term_i;
        logic [32:0] s_i;
        logic [31:0] q0, q;
        logic [35:0] rem;

        if (j == 0) begin : g_first
            assign t_i    = t3_reg;
            assign y_i    = y3_reg;
            assign s_i    = s3_reg;
            assign term_i = y3_reg;
        end else begin : g_next
            assign t_i    = tc_reg[j-1];
            assign y_i    = yc_reg[j-1];
            assign s_i    = sc_reg[j-1];
            assign term_i = term_reg[j-1];
        end

        assign q0  = pm_reg[j][65:34];
        assign rem = 36'(v_reg[j]) - 36'(q0) * 36'(N);
        assign q   = (rem >= 36'(N)) ? q0 + 32'd1 : q0;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tm_reg[j] <= '0;
                tr_reg[j] <= '0;
                tc_reg[j] <= '0;
            end else if (adv) begin
                tm_reg[j] <= t_i;
                tr_reg[j] <= tm_reg[j];
                tc_reg[j] <= tr_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                prod_reg[j] <= 64'(term_i) * 64'(y_i);
                ym_reg[j]   <= y_i;
                sm_reg[j]   <= s_i;
                v_reg[j]    <= prod_reg[j][63:32];
                pm_reg[j]   <= 66'(prod_reg[j][63:32]) * 66'(RCP);
                yr_reg[j]   <= ym_reg[j];
                sr_reg[j]   <= sm_reg[j];
                sc_reg[j]   <= (N % 2 == 1) ? sr_reg[j] - 33'(q) : sr_reg[j] + 33'(q);
            end
        end

        if (j < NT - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    yc_reg[j]   <= yr_reg[j];
                    term_reg[j] <= q;
                end
            end
        end
    end

    // four squarings in q30
    for (genvar i = 0; i < NSQ; i++) begin : g_sq
        pdre_pkg::tag_t t_i;
        logic [30:0] x_i;
        logic [61:0] p_i;

        if (i == 0) begin : g_first
            assign t_i = tc_reg[NT-1];
            assign x_i = sc_reg[NT-1][32:2];
        end else begin : g_next
            assign t_i = tq_reg[i-1];
            assign x_i = sq_reg[i-1];
        end

        assign p_i = 62'(x_i) * 62'(x_i);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tq_reg[i] <= '0;
            end else if (adv) begin
                tq_reg[i] <= t_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) sq_reg[i] <= p_i[60:30];
        end
    end

    assign rnd_sum = 32'(sq_reg[NSQ-1]) + 32'd8192;
    assign rnd     = rnd_sum[30:14];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            to_reg <= '0;
        end else if (adv) begin
            to_reg <= tq_reg[NSQ-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            basis_reg <= tq_reg[NSQ-1].zero ? '0
                       : (rnd[16] ? 16'hFFFF : rnd[15:0]);
        end
    end

    assign m_tvalid = to_reg.vld;
    assign m_tlast  = to_reg.last;
    assign m_tdata  = {5'd0, to_reg.pair_dist, basis_reg, to_reg.bin};

endmodule

FILE: hw/rtl/pairwise_distance_rbf_expander.sv
// pairwise_distance_rbf_expander: top level, distance of a carbon pair and its gaussian bins
//
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tdata: first_x, first_y, first_z, second_x, ...
// m_        out  m_tvalid/m_tready    tdata: bin_index, basis_value, pair_distance; tlast
//
// one request gives NUM_BINS results, one per cycle unless m_tready stalls
// the front works each request through squares, sum and a 22-step bitwise root, which the
// two-entry distance queue hides behind the back's bin stream
// from queue head a bin passes input stages, series terms, squarings and output register
// synchronous active-low reset clears control state and pipeline tags, not the data path
// m_tready stalls freeze the whole gaussian pipeline; the front runs until the queue fills
module pairwise_distance_rbf_expander #(
    parameter int NUM_BINS   = 64,
    parameter int COORD_BITS = 20
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, zero fill
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // bin_index[5:0], basis_value[21:6], pair_distance[42:22], zero fill
    output logic [pdre_pkg::OUT_DATA_W-1:0]        m_tdata,
    // last_bin
    output logic                                   m_tlast
);

    // front to queue
    logic            push_valid, push_ready;
    pdre_pkg::dist_t push_dist;
    // queue to back
    logic            q_valid, q_pop;
    pdre_pkg::dist_t q_dist;

    // distance front end, padding bits of tdata are dropped
    pdre_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .coords     (s_tdata[6*COORD_BITS-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_dist  (push_dist)
    );

    // short queue lets front and back stall apart
    pdre_fifo #(.WIDTH(pdre_pkg::DIST_W)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_dist),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_dist)
    );

    // bin stream and gaussian pipeline
    pdre_back #(.NUM_BINS(NUM_BINS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_dist   (q_dist),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/pdre_checker.sv
// pdre_checker: port-level assertions for the expander and its bind
module pdre_checker #(
    parameter int NUM_BINS = 64
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [pdre_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                m_tlast
);

    logic [5:0]  exp_bin_reg;
    logic [20:0] dist_reg;
    logic        mid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_bin_reg <= '0;
            mid_reg     <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            exp_bin_reg <= m_tlast ? 6'd0 : exp_bin_reg + 6'd1;
            mid_reg     <= !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tvalid && m_tready) dist_reg <= m_tdata[42:22];
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_bin_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:0] == exp_bin_reg)
        else $error("bins out of order");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == (m_tdata[5:0] == 6'(NUM_BINS - 1)))
        else $error("last flag not on final bin");

    a_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mid_reg |-> m_tdata[42:22] == dist_reg)
        else $error("distance changed within a run");

endmodule

bind pairwise_distance_rbf_expander pdre_checker #(.NUM_BINS(NUM_BINS)) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/pairwise_distance_rbf_expander_checker.sv
// checker for the distance rbf expander: predicts every bin of each request and compares
module pairwise_distance_rbf_expander_checker #(
    parameter int NUM_BINS   = 64,
    parameter int COORD_BITS = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [pdre_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                m_tlast,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  bins_seen
);

    typedef struct packed {
        logic [pdre_pkg::BIN_W-1:0]   bin;
        logic [pdre_pkg::BASIS_W-1:0] basis;
        pdre_pkg::dist_t              pair_dist;
        logic                         last;
    } bin_result_t;

    bin_result_t bin_queue[$];

    function automatic longint signed coord_of(input logic [COORD_BITS-1:0] raw);
        longint signed v;
        v = longint'(raw);
        if (raw[COORD_BITS-1])
            v = v - (longint'(1) << COORD_BITS);
        return v;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned r, b, m;
        r = 0;
        b = 64'd1 << 62;
        m = n;
        while (b > m)
            b = b >> 2;
        while (b != 0) begin
            if (m >= r + b) begin
                m = m - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [pdre_pkg::BASIS_W-1:0] gauss_of(input longint unsigned e);
        longint unsigned e2, y, s, term;
        if (e >= 32768)
            return '0;
        e2 = e * e;
        if (e2 >= 64'd629145600)
            return '0;
        y = ((e2 * 2048) / 25) >> 4;
        s = 64'd1 << 32;
        term = s;
        for (int n = 1; n <= 12; n++) begin
            // product fits: term <= 2^32, y < 2^32
            term = ((term * y) >> 32) / n;
            if (n % 2 == 1)
                s = s - term;
            else
                s = s + term;
        end
        s = s >> 2;
        for (int i = 0; i < 4; i++)
            s = (s * s) >> 30;
        s = (s + 8192) >> 14;
        if (s > 65535)
            s = 65535;
        return s[pdre_pkg::BASIS_W-1:0];
    endfunction

    task automatic predict_bins(input logic [((6*COORD_BITS+7)/8)*8-1:0] d);
        longint signed c[6];
        longint unsigned dx, dy, dz, pair_dist, scaled, ctr, e;
        bin_result_t r;
        for (int i = 0; i < 6; i++)
            c[i] = coord_of(d[i*COORD_BITS +: COORD_BITS]);
        dx = (c[0] > c[3]) ? c[0] - c[3] : c[3] - c[0];
        dy = (c[1] > c[4]) ? c[1] - c[4] : c[4] - c[1];
        dz = (c[2] > c[5]) ? c[2] - c[5] : c[5] - c[2];
        if (dx > pdre_pkg::DIST_MAX || dy > pdre_pkg::DIST_MAX || dz > pdre_pkg::DIST_MAX)
            pair_dist = pdre_pkg::DIST_MAX;
        else begin
            pair_dist = int_root(dx*dx + dy*dy + dz*dz);
            if (pair_dist > pdre_pkg::DIST_MAX)
                pair_dist = pdre_pkg::DIST_MAX;
        end
        scaled = pair_dist * (NUM_BINS - 1);
        for (int k = 0; k < NUM_BINS; k++) begin
            ctr = k * 5120;
            e = (scaled >= ctr) ? scaled - ctr : ctr - scaled;
            r.bin = k[pdre_pkg::BIN_W-1:0];
            r.basis = gauss_of(e);
            r.pair_dist = pair_dist[pdre_pkg::DIST_W-1:0];
            r.last = (k == NUM_BINS - 1);
            bin_queue = {bin_queue, r};
        end
    endtask

    bin_result_t got, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count <= 0;
            bins_seen <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_bins(s_tdata);
            if (m_tvalid && m_tready) begin
                bins_seen <= bins_seen + 1;
                got.bin = m_tdata[5:0];
                got.basis = m_tdata[21:6];
                got.pair_dist = m_tdata[42:22];
                got.last = m_tlast;
                if (bin_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result bin=%0d basis=%0d dist=%0d",
                                 got.bin, got.basis, got.pair_dist);
                    fail_count <= fail_count + 1;
                end else begin
                    want = bin_queue.pop_front();
                    if (got != want) begin
                        if (fail_count < 10)
                            $display("mismatch exp bin=%0d basis=%0d dist=%0d last=%0b %s",
                                     want.bin, want.basis, want.pair_dist, want.last,
                                     $sformatf("got bin=%0d basis=%0d dist=%0d last=%0b",
                                               got.bin, got.basis, got.pair_dist, got.last));
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending = bin_queue.size();
    end
endmodule

FILE: tb/pairwise_distance_rbf_expander_test.sv
// top of the distance rbf expander test: stimulus, idling, watchdog and verdict
module pairwise_distance_rbf_expander_test;

    localparam int NB = 64;
    localparam int CB = 20;
    localparam int IN_W = ((6*CB+7)/8)*8;
    localparam int RANDOM_REQS = 166;
    // quiet cycles allowed: pipeline fill plus a full stalled bin stream
    localparam int QUIET_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pdre_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;
    int fail_count, pending, bins_seen;
    int quiet = 0;
    int sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pairwise_distance_rbf_expander #(.NUM_BINS(NB), .COORD_BITS(CB)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    pairwise_distance_rbf_expander_checker #(.NUM_BINS(NB), .COORD_BITS(CB)) u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending), .bins_seen(bins_seen)
    );

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog expired, %0d bins outstanding", pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall per result, some stretches always ready
    initial begin
        int gap;
        int burst;
        burst = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (burst > 0) begin
                gap = 0;
                burst--;
            end else begin
                gap = $urandom_range(0, 13);
                if ($urandom_range(0, 15) == 0)
                    burst = $urandom_range(20, 150);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_pair(input logic [CB-1:0] c0, c1, c2, c3, c4, c5, input bit nogap);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c5, c4, c3, c2, c1, c0};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    function automatic logic [CB-1:0] rnd_coord();
        return CB'($urandom());
    endfunction

    logic [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
    logic [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};

    initial begin
        logic [CB-1:0] bx, by, bz, dd;
        int wait_n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero distance, each axis at its extremes, largest distance, on centers
        send_pair('0, '0, '0, '0, '0, '0, 0);
        send_pair(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 0);
        send_pair(MAXC, '0, '0, MINC, '0, '0, 1);
        send_pair('0, MINC, '0, '0, MAXC, '0, 1);
        send_pair('0, '0, MAXC, '0, '0, MINC, 0);
        send_pair(MAXC, MAXC, MAXC, MINC, MINC, MINC, 0);
        send_pair(MINC, MINC, MINC, MAXC, MAXC, MAXC, 0);
        send_pair('1, '1, '1, '0, '0, '0, 0);
        // near bin centers: 20/63 angstrom steps hit k*5120 when dist*63 divisible by 5120
        send_pair(CB'(5120), '0, '0, '0, '0, '0, 0);
        send_pair('0, CB'(2560), '0, '0, '0, '0, 0);
        send_pair('0, '0, CB'(81), '0, '0, '0, 1);
        send_pair(CB'(3000), CB'(4000), '0, '0, '0, '0, 0);
        send_pair(CB'(1), '0, '0, '0, '0, '0, 0);
        send_pair(CB'(5200), '0, '0, '0, '0, '0, 0);

        // random: mostly realistic distances inside 0..25 angstrom, some full range
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_pair(rnd_coord(), rnd_coord(), rnd_coord(),
                          rnd_coord(), rnd_coord(), rnd_coord(), $urandom_range(0, 3) == 0);
            else begin
                bx = rnd_coord();
                by = rnd_coord();
                bz = rnd_coord();
                dd = CB'($urandom_range(0, 6400));
                send_pair(bx, by, bz, bx + dd, by - CB'($urandom_range(0, 3000)),
                          bz + CB'($urandom_range(0, 3000)), $urandom_range(0, 3) == 0);
            end
        end
        s_tvalid <= 1'b0;

        wait_n = 0;
        while (pending != 0 && wait_n < 400000) begin
            @(posedge aclk);
            wait_n++;
        end
        repeat (200) @(posedge aclk);

        $display("sent %0d coordinate pairs, checked %0d bins", sent, bins_seen);
        $display("random pairs mixed near and far distances with stalls on both channels");
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
